@@ rtl/cptl_pkg.sv @@
`default_nettype none
package cptl_pkg;

    localparam int CHUNK_SIZE = 4096;
    localparam int ADDR_W     = $clog2(CHUNK_SIZE);
    localparam int CNT_W      = $clog2(CHUNK_SIZE + 1);
    localparam int LH_W       = CNT_W + 2;

    localparam int OFF_W   = 12;
    localparam int VAL_W   = 8;
    localparam int ENT_W   = OFF_W + VAL_W + 1;
    localparam int CYC_W   = 32;
    localparam int LAST_W  = 13;
    localparam int OCC_W   = 13;
    localparam int OCC_MAX = (1 << OCC_W) - 1;
    localparam int ACC_W   = CNT_W + OFF_W + 1;

    // slave tdata layout, lowest bit first
    localparam int QC_LSB   = 0;
    localparam int EOFF_LSB = QC_LSB + CYC_W;
    localparam int EVAL_LSB = EOFF_LSB + OFF_W;
    localparam int EDEF_BIT = EVAL_LSB + VAL_W;
    localparam int PDEF_BIT = EDEF_BIT + 1;
    localparam int LAST_LSB = PDEF_BIT + 1;
    localparam int S_USED_W = LAST_LSB + LAST_W;
    localparam int S_DATA_W = ((S_USED_W + 7) / 8) * 8;

    // master tdata layout
    localparam int M_USED_W = VAL_W + CYC_W + OCC_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - M_USED_W;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_OCC    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_FOUND    = 3'd0,
        STAT_NOTFOUND = 3'd1,
        STAT_UNDEF    = 3'd2,
        STAT_DONE     = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic load;
        logic exec_cl;
        logic exec_ap;
        logic res_nf;
        logic res_occ0;
        logic rd0;
        logic lk_init;
        logic lk_rd;
        logic lk_res;
        logic lk_step;
        logic walk_start;
        logic walk;
        logic occ_fin;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    out_free;
        logic    cnt_zero;
        logic    first_gt;
        logic    lk_empty;
        logic    lk_match;
        logic    walk_done;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/cptl_ctrl.sv @@
`default_nettype none
module cptl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire cptl_pkg::sts_t sts,
    output cptl_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_LK_CHK0 = 6'b000100,
        S_LK_RD   = 6'b001000,
        S_LK_EVAL = 6'b010000,
        S_OC_RUN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.act)
                    cptl_pkg::ACT_CLEAR:  cmd.exec_cl = 1'b1;
                    cptl_pkg::ACT_APPEND: cmd.exec_ap = 1'b1;
                    cptl_pkg::ACT_LOOKUP:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_nf = 1'b1;
                        end
                        else
                        begin
                            cmd.rd0    = 1'b1;
                            state_next = S_LK_CHK0;
                        end
                    end
                    cptl_pkg::ACT_OCC:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_occ0 = 1'b1;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_OC_RUN;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_LK_CHK0:
            begin
                if (sts.first_gt)
                begin
                    cmd.res_nf = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.lk_init = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                // search range exhausted only when offsets are not strictly ascending
                if (sts.lk_empty)
                begin
                    cmd.res_nf = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.lk_rd  = 1'b1;
                    state_next = S_LK_EVAL;
                end
            end
            S_LK_EVAL:
            begin
                if (sts.lk_match)
                begin
                    cmd.lk_res = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.lk_step = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_OC_RUN:
            begin
                if (sts.walk_done)
                begin
                    cmd.occ_fin = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/cptl_dp.sv @@
`default_nettype none
module cptl_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cptl_pkg::cmd_t                  cmd,
    output cptl_pkg::sts_t                       sts,
    input  wire logic [cptl_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic [cptl_pkg::CYC_W-1:0]      cfg_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cptl_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [2:0]                           m_tuser
);

    localparam int ADDR_W = cptl_pkg::ADDR_W;
    localparam int CNT_W  = cptl_pkg::CNT_W;
    localparam int LH_W   = cptl_pkg::LH_W;
    localparam int OFF_W  = cptl_pkg::OFF_W;
    localparam int VAL_W  = cptl_pkg::VAL_W;
    localparam int ENT_W  = cptl_pkg::ENT_W;
    localparam int CYC_W  = cptl_pkg::CYC_W;
    localparam int LAST_W = cptl_pkg::LAST_W;
    localparam int OCC_W  = cptl_pkg::OCC_W;
    localparam int ACC_W  = cptl_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] OCC_MAX_S = ACC_W'(cptl_pkg::OCC_MAX);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(cptl_pkg::CHUNK_SIZE);

    // entry store: {defined, value, offset}
    logic [ENT_W-1:0] mem [cptl_pkg::CHUNK_SIZE];
    logic [ENT_W-1:0] rd_a, rd_b;
    logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;
    logic              mem_we;
    logic [ENT_W-1:0]  wr_data;

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CYC_W-1:0] base_reg, base_next;
    logic             out_valid_reg, out_valid_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             first_reg, first_next;

    // payload
    cptl_pkg::action_t act_reg, act_next;
    logic [CYC_W-1:0]  q_reg, q_next;
    logic [OFF_W-1:0]  eoff_reg, eoff_next;
    logic [VAL_W-1:0]  eval_reg, eval_next;
    logic              edef_reg, edef_next;
    logic              prior_reg, prior_next;
    logic [LAST_W-1:0] last_reg, last_next;
    logic signed [LH_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [OFF_W-1:0]  poff_reg, poff_next;
    logic              pdef_reg, pdef_next;
    cptl_pkg::status_t out_stat_reg, out_stat_next;
    logic [VAL_W-1:0]  out_val_reg, out_val_next;
    logic [CYC_W-1:0]  out_set_reg, out_set_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;

    logic signed [LH_W-1:0] mid_sum, mid;
    logic [CNT_W-1:0]  mid_idx, mid1;
    logic [OFF_W-1:0]  off_a, off_b;
    logic              def_a, walk_more, full;
    logic signed [ACC_W-1:0] last_s, poff_s, off_s, occ_sum;
    logic [OCC_W-1:0]  occ_sat;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

    always_comb
    begin
        off_a   = rd_a[OFF_W-1:0];
        def_a   = rd_a[ENT_W-1];
        off_b   = rd_b[OFF_W-1:0];
        mid_sum = lo_reg + hi_reg;
        mid     = mid_sum >>> 1;
        mid_idx = mid[CNT_W-1:0];
        mid1    = mid_idx + CNT_W'(1);
        walk_more = rd_idx_reg < count_reg;
        full    = count_reg >= FULL_CNT;

        last_s  = ACC_W'(last_reg);
        poff_s  = ACC_W'(poff_reg);
        off_s   = ACC_W'(off_a);
        occ_sum = acc_reg + (pdef_reg ? (last_s - poff_s) : '0);
        if (occ_sum < 0)
        begin
            occ_sat = '0;
        end
        else if (occ_sum > OCC_MAX_S)
        begin
            occ_sat = OCC_MAX_S[OCC_W-1:0];
        end
        else
        begin
            occ_sat = occ_sum[OCC_W-1:0];
        end

        sts.act       = act_reg;
        sts.out_free  = !out_valid_reg || m_tready;
        sts.cnt_zero  = count_reg == '0;
        sts.first_gt  = CYC_W'(off_a) > q_reg;
        sts.lk_empty  = lo_reg > hi_reg;
        sts.lk_match  = (CYC_W'(off_a) <= q_reg)
                        && ((mid1 == count_reg) || (CYC_W'(off_b) > q_reg));
        sts.walk_done = !walk_more && !rd_vld_reg;
    end

    always_comb
    begin
        addr_a = '0;
        if (cmd.lk_rd)
        begin
            addr_a = mid_idx[ADDR_W-1:0];
        end
        else if (cmd.walk)
        begin
            addr_a = rd_idx_reg[ADDR_W-1:0];
        end
        addr_b  = mid1[ADDR_W-1:0];
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = {edef_reg, eval_reg, eoff_reg};
        mem_we  = cmd.exec_ap && !full;
    end

    always_comb
    begin
        count_next     = count_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_vld_next    = 1'b0;
        first_next     = first_reg;
        act_next       = act_reg;
        q_next         = q_reg;
        eoff_next      = eoff_reg;
        eval_next      = eval_reg;
        edef_next      = edef_reg;
        prior_next     = prior_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_idx_next    = rd_idx_reg;
        acc_next       = acc_reg;
        poff_next      = poff_reg;
        pdef_next      = pdef_reg;
        out_stat_next  = out_stat_reg;
        out_val_next   = out_val_reg;
        out_set_next   = out_set_reg;
        out_occ_next   = out_occ_reg;

        if (cfg_valid)
        begin
            base_next = cfg_data;
        end

        if (cmd.load)
        begin
            act_next   = cptl_pkg::action_t'(s_tuser);
            q_next     = s_tdata[cptl_pkg::QC_LSB +: CYC_W] - base_reg;
            eoff_next  = s_tdata[cptl_pkg::EOFF_LSB +: OFF_W];
            eval_next  = s_tdata[cptl_pkg::EVAL_LSB +: VAL_W];
            edef_next  = s_tdata[cptl_pkg::EDEF_BIT];
            prior_next = s_tdata[cptl_pkg::PDEF_BIT];
            last_next  = s_tdata[cptl_pkg::LAST_LSB +: LAST_W];
        end

        if (cmd.lk_init)
        begin
            lo_next = '0;
            hi_next = LH_W'(count_reg) - LH_W'(1);
        end
        if (cmd.lk_step)
        begin
            if (CYC_W'(off_a) < q_reg)
            begin
                lo_next = mid + LH_W'(1);
            end
            else
            begin
                hi_next = mid - LH_W'(1);
            end
        end

        if (cmd.walk_start)
        begin
            rd_idx_next = '0;
            first_next  = 1'b1;
            acc_next    = '0;
        end
        if (cmd.walk && walk_more)
        begin
            rd_vld_next = 1'b1;
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        // entry read in the previous cycle lands here
        if (rd_vld_reg)
        begin
            first_next = 1'b0;
            poff_next  = off_a;
            pdef_next  = def_a;
            if (first_reg)
            begin
                acc_next = prior_reg ? off_s : '0;
            end
            else if (pdef_reg)
            begin
                acc_next = acc_reg + (off_s - poff_s);
            end
        end

        if (cmd.exec_cl || cmd.exec_ap || cmd.res_nf || cmd.res_occ0
            || cmd.lk_res || cmd.occ_fin)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = cptl_pkg::STAT_DONE;
            out_val_next   = '0;
            out_set_next   = '0;
            out_occ_next   = '0;
            if (cmd.exec_cl)
            begin
                count_next = '0;
            end
            if (cmd.exec_ap)
            begin
                if (full)
                begin
                    out_stat_next = cptl_pkg::STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            if (cmd.res_nf)
            begin
                out_stat_next = cptl_pkg::STAT_NOTFOUND;
            end
            if (cmd.res_occ0)
            begin
                out_occ_next = prior_reg ? OCC_W'(last_reg) : '0;
            end
            if (cmd.lk_res)
            begin
                if (def_a)
                begin
                    out_stat_next = cptl_pkg::STAT_FOUND;
                    out_val_next  = rd_a[OFF_W +: VAL_W];
                    out_set_next  = base_reg + CYC_W'(off_a);
                end
                else
                begin
                    out_stat_next = cptl_pkg::STAT_UNDEF;
                end
            end
            if (cmd.occ_fin)
            begin
                out_occ_next = occ_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        q_reg        <= q_next;
        eoff_reg     <= eoff_next;
        eval_reg     <= eval_next;
        edef_reg     <= edef_next;
        prior_reg    <= prior_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        rd_idx_reg   <= rd_idx_next;
        acc_reg      <= acc_next;
        poff_reg     <= poff_next;
        pdef_reg     <= pdef_next;
        out_stat_reg <= out_stat_next;
        out_val_reg  <= out_val_next;
        out_set_reg  <= out_set_next;
        out_occ_reg  <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {{cptl_pkg::M_PAD_W{1'b0}}, out_occ_reg, out_set_reg, out_val_reg};

endmodule
`default_nettype wire

@@ rtl/change_point_table_lookup_top.sv @@
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    tuser: action; tdata: query_cycle, entry_offset,
//                                     entry_value, entry_defined, prior_defined, last_cycle
// m_axis    out  m_tvalid/m_tready    tuser: status; tdata: found_value, set_at_cycle,
//                                     occupancy
// cfg       in   cfg_valid/cfg_ready  cfg_data: base_cycle
//
// One item at a time. Clear and append: result registered in the execute state.
// Lookup: binary search with probes of the 2-read-port entry RAM.
// Occupancy: one RAM read per entry.
// Reset clears the entry count and base_cycle; entry RAM is not cleared.
// The result sits in an output register; a new beat is taken once the block is
// idle and that register is empty or draining in the same cycle.
`default_nettype none
module change_point_table_lookup_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] query_cycle, [43:32] entry_offset, [51:44] entry_value,
    // [52] entry_defined, [53] prior_defined, [66:54] last_cycle, [71:67] zero
    input  wire logic [cptl_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] found_value, [39:8] set_at_cycle, [52:40] occupancy, [55:53] zero
    output logic [cptl_pkg::M_DATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [2:0]                         m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cptl_pkg::CYC_W-1:0]    cfg_data
);

    cptl_pkg::cmd_t cmd;
    cptl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    cptl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cptl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/cptl_checker.sv @@
`default_nettype none
module cptl_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [cptl_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic [2:0]                    m_tuser
);

    // held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= cptl_pkg::STAT_FULL))
        else $error("bad status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != cptl_pkg::STAT_FOUND) |-> (m_tdata[39:0] == '0))
        else $error("value fields set without a match");

    a_occ_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != cptl_pkg::STAT_DONE) |-> (m_tdata[52:40] == '0))
        else $error("occupancy set on a non-done result");

endmodule

bind change_point_table_lookup_top cptl_checker u_cptl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ dv/change_point_table_lookup_checker.sv @@
`default_nettype none
module change_point_table_lookup_checker
    import cptl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DATA_W-1:0]   m_tdata,
    input  wire logic [2:0]            m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CYC_W-1:0]      cfg_data,
    output int unsigned                fail_count,
    output int unsigned                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 100;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   value;
        logic [CYC_W-1:0]   set_at;
        logic [OCC_W-1:0]   occ;
    } cp_result_t;

    // shadow copy of the change-point store: [11:0] offset, [19:12] value, [20] defined
    logic [ENT_W-1:0]   cp_table [CHUNK_SIZE];
    int unsigned        cp_count;
    logic [CYC_W-1:0]   base_cyc;
    cp_result_t         result_q [$];
    int unsigned        n_fail;

    function automatic logic [OFF_W-1:0] ent_off(input int i);
        return cp_table[i][OFF_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] ent_val(input int i);
        return cp_table[i][OFF_W +: VAL_W];
    endfunction

    function automatic logic ent_def(input int i);
        return cp_table[i][ENT_W-1];
    endfunction

    // last entry at or before the queried cycle, offset taken as unsigned 32-bit difference
    function automatic cp_result_t search_table(input logic [CYC_W-1:0] qc);
        cp_result_t       r;
        logic [CYC_W-1:0] rel;
        int               lo;
        int               hi;
        int               mid;
        r = '0;
        r.status = STAT_NOTFOUND;
        rel = qc - base_cyc;
        if (cp_count == 0 || ent_off(0) > rel)
            return r;
        lo = 0;
        hi = int'(cp_count) - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) >>> 1;
            if (ent_off(mid) <= rel && (mid + 1 == int'(cp_count) || ent_off(mid + 1) > rel))
            begin
                if (!ent_def(mid))
                    r.status = STAT_UNDEF;
                else
                begin
                    r.status = STAT_FOUND;
                    r.value  = ent_val(mid);
                    r.set_at = base_cyc + CYC_W'(ent_off(mid));
                end
                return r;
            end
            if (ent_off(mid) < rel)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    // defined-cycle count; signed sum so unsorted tables can go out of range, then clamp
    function automatic logic [OCC_W-1:0] defined_span(input logic prior,
                                                      input logic [LAST_W-1:0] last_cyc);
        longint acc;
        int     n;
        int     i;
        n = int'(cp_count);
        if (n == 0)
            return prior ? OCC_W'(last_cyc) : '0;
        acc = prior ? longint'(ent_off(0)) : 0;
        for (i = 0; i + 1 < n; i++)
            if (ent_def(i))
                acc += longint'(ent_off(i + 1)) - longint'(ent_off(i));
        if (ent_def(n - 1))
            acc += longint'(last_cyc) - longint'(ent_off(n - 1));
        if (acc < 0)
            acc = 0;
        if (acc > OCC_MAX)
            acc = OCC_MAX;
        return OCC_W'(acc);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            n_fail++;
            if (n_fail <= REPORT_CAP)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cp_result_t want;
        cp_result_t pred;
        if (!rst_n)
        begin
            cp_count = 0;
            base_cyc = '0;
            result_q.delete();
            n_fail = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // results first: a beat leaving now belongs to an earlier input
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= REPORT_CAP)
                        $error("result beat with nothing predicted: status %0d", m_tuser);
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("found_value", want.value, m_tdata[VAL_W-1:0]);
                    check_field("set_at_cycle", want.set_at, m_tdata[VAL_W +: CYC_W]);
                    check_field("occupancy", want.occ, m_tdata[VAL_W + CYC_W +: OCC_W]);
                    check_field("pad", '0, m_tdata[M_DATA_W-1:M_USED_W]);
                end
            end

            if (cfg_valid && cfg_ready)
                base_cyc = cfg_data;

            if (s_tvalid && s_tready)
            begin
                pred = '0;
                pred.status = STAT_DONE;
                case (action_t'(s_tuser))
                    ACT_CLEAR:
                        cp_count = 0;
                    ACT_APPEND:
                        if (cp_count >= CHUNK_SIZE)
                            pred.status = STAT_FULL;
                        else
                        begin
                            cp_table[cp_count] = {s_tdata[EDEF_BIT],
                                                  s_tdata[EVAL_LSB +: VAL_W],
                                                  s_tdata[EOFF_LSB +: OFF_W]};
                            cp_count++;
                        end
                    ACT_LOOKUP:
                        pred = search_table(s_tdata[QC_LSB +: CYC_W]);
                    default:
                        pred.occ = defined_span(s_tdata[PDEF_BIT],
                                                s_tdata[LAST_LSB +: LAST_W]);
                endcase
                result_q.push_back(pred);
            end

            fail_count <= n_fail;
            pending <= result_q.size();
        end
    end

endmodule
`default_nettype wire

@@ dv/tb_change_point_table_lookup_top.sv @@
`default_nettype none
module tb_change_point_table_lookup_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cptl_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 640;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;   // query_cycle, entry_offset, entry_value,
                                       // entry_defined, prior_defined, last_cycle
    logic [1:0]             s_tuser;   // action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;   // found_value, set_at_cycle, occupancy
    logic [2:0]             m_tuser;   // status
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CYC_W-1:0]       cfg_data;

    int unsigned            fail_count;
    int unsigned            pending;

    int unsigned            cycle_cnt;
    int                     burst_left;
    bit                     steady;
    logic [CYC_W-1:0]       base_now;
    int                     n_act [4];
    int                     n_cfg;
    int                     offs [$];

    always #6 clk = ~clk;

    change_point_table_lookup_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    change_point_table_lookup_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver backpressure: one of four modes, redrawn at random intervals
    int unsigned rx_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_tick = 0;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(32, 300);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_tick % 5) < 2;
        endcase
    end

    task automatic put(input action_t act, input logic [31:0] qc, input logic [11:0] off,
                       input logic [7:0] val, input logic edef, input logic pdef,
                       input logic [12:0] lc);
        logic [S_DATA_W-1:0] d;
        int                  gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 7);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        d = '0;
        d[QC_LSB +: CYC_W]   = qc;
        d[EOFF_LSB +: OFF_W] = off;
        d[EVAL_LSB +: VAL_W] = val;
        d[EDEF_BIT]          = edef;
        d[PDEF_BIT]          = pdef;
        d[LAST_LSB +: LAST_W] = lc;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_act[act]++;
    endtask

    // fields the action ignores carry random in-range junk
    task automatic put_clear();
        put(ACT_CLEAR, $urandom, 12'($urandom), 8'($urandom), 1'($urandom),
            1'($urandom), 13'($urandom_range(0, 4096)));
    endtask

    task automatic put_append(input logic [11:0] off, input logic [7:0] val,
                              input logic edef);
        put(ACT_APPEND, $urandom, off, val, edef, 1'($urandom), 13'($urandom_range(0, 4096)));
    endtask

    task automatic put_lookup(input logic [31:0] qc);
        put(ACT_LOOKUP, qc, 12'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
            13'($urandom_range(0, 4096)));
    endtask

    task automatic put_occ(input logic pdef, input logic [12:0] lc);
        put(ACT_OCC, $urandom, 12'($urandom), 8'($urandom), 1'($urandom), pdef, lc);
    endtask

    // stop sending and hold until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [CYC_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        base_now = v;
        n_cfg++;
    endtask

    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL change_point_table_lookup_top");
        $finish;
    end

    initial
    begin : stimulus
        int         rnd_start;
        int         n;
        int         k;
        int         cur;
        int         idx;
        logic [31:0] rel;
        int         top_off;
        int         pick;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_CLEAR;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 0;
        steady     = 1'b0;
        base_now   = '0;
        n_cfg      = 0;
        foreach (n_act[i])
            n_act[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, base still at its reset value
        put_lookup(32'd0);
        put_occ(1'b1, 13'd4096);
        put_occ(1'b0, 13'd4096);
        put_append(12'd0, 8'h00, 1'b0);
        put_append(12'd100, 8'hFF, 1'b1);
        put_append(12'd4095, 8'hA5, 1'b1);
        put_lookup(32'd0);            // undefined entry
        put_lookup(32'd50);
        put_lookup(32'd100);
        put_lookup(32'd4095);
        put_lookup(32'hFFFF_FFFF);    // far past the last entry
        put_occ(1'b0, 13'd4096);
        put_occ(1'b1, 13'd0);         // end below last offset, clamps at zero
        put_clear();
        put_append(12'd10, 8'h3C, 1'b1);
        put_lookup(32'd5);            // before the first entry
        put_append(12'd4095, 8'h11, 1'b1);
        put_append(12'd0, 8'h22, 1'b1);   // out of order
        put_lookup(32'd10);
        put_occ(1'b1, 13'd0);

        // base near the signed wrap point
        write_base(32'h7FFF_FFFF);
        put_lookup(32'h7FFF_FFFE);    // query below base: huge unsigned offset
        put_lookup(32'h8000_0009);
        put_clear();

        // sum far above the occupancy range
        write_base(32'h8000_0000);
        repeat (2)
        begin
            put_append(12'd0, 8'h01, 1'b1);
            put_append(12'd4095, 8'h02, 1'b0);
        end
        put_append(12'd0, 8'h03, 1'b1);
        put_append(12'd4095, 8'h04, 1'b1);
        put_occ(1'b1, 13'd4096);
        drain_results();

        // random: mostly clear/append/query episodes, some noise
        rnd_start = n_act[0] + n_act[1] + n_act[2] + n_act[3];
        while (n_act[0] + n_act[1] + n_act[2] + n_act[3] - rnd_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                case ($urandom_range(0, 5))
                    0: write_base(32'h0000_0000);
                    1: write_base(32'h7FFF_FFFF);
                    2: write_base(32'h8000_0000);
                    3: write_base(32'hFFFF_FFFF);
                    4: write_base(32'($urandom_range(0, 65535)));
                    default: write_base($urandom);
                endcase
            end
            else if (pick < 18)
                drain_results();
            steady = ($urandom_range(0, 4) == 0);

            if ($urandom_range(0, 99) < 85)
            begin
                put_clear();
                offs.delete();
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 24);
                cur = $urandom_range(0, 63);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        cur += $urandom_range(0, (n > 50) ? 12 : 250);
                    if (cur > 4095)
                        cur = 4095;
                    put_append(12'(cur), 8'($urandom), ($urandom_range(0, 3) != 0));
                    offs.push_back(cur);
                end
                top_off = (offs.size() > 0) ? offs[$] : 0;
                k = $urandom_range(2, 10);
                repeat (k)
                begin
                    if ($urandom_range(0, 9) < 6)
                    begin
                        idx = (offs.size() > 0) ? $urandom_range(0, offs.size() - 1) : 0;
                        case ($urandom_range(0, 4))
                            0: rel = (offs.size() > 0) ? offs[idx] : 0;
                            1: rel = (offs.size() > 0) ? offs[idx] - 1 : 32'hFFFF_FFFF;
                            2: rel = (offs.size() > 0) ? offs[idx] + 1 : 1;
                            3: rel = $urandom_range(0, 4095);
                            default: rel = $urandom;
                        endcase
                        put_lookup(base_now + rel);
                    end
                    else if ($urandom_range(0, 3) == 0)
                        put_occ(1'($urandom), 13'($urandom_range(0, 4096)));
                    else
                        put_occ(1'($urandom), 13'($urandom_range(top_off, 4096)));
                end
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                    put(action_t'($urandom_range(0, 3)), $urandom, 12'($urandom),
                        8'($urandom), 1'($urandom), 1'($urandom),
                        13'($urandom_range(0, 4096)));
            end
        end

        drain_results();
        repeat (40) @(posedge clk);

        $display("covered %0d clears, %0d appends, %0d lookups, %0d occupancy queries",
                 n_act[ACT_CLEAR], n_act[ACT_APPEND], n_act[ACT_LOOKUP], n_act[ACT_OCC]);
        $display("with %0d base_cycle writes incl. both sign extremes and unsorted tables",
                 n_cfg);
        if (fail_count == 0)
            $display("PASS change_point_table_lookup_top");
        else
            $display("FAIL change_point_table_lookup_top");
        $finish;
    end

endmodule
`default_nettype wire
